// ===== design/nge_pkg.sv =====
`timescale 1ns / 1ps
// Shared types for the next greater element block: item and result structs,
// controller states and the command/status bundles between control and datapath.
// No dependencies.
package nge_pkg;

	// Fixed field widths of the channels
	localparam int VALUE_IN_W  = 32;
	localparam int INDEX_OUT_W = 6;

	// One input item
	typedef struct packed {
		logic [VALUE_IN_W-1:0] value;
		logic                  last;
	} item_t;

	// One result item
	typedef struct packed {
		logic [INDEX_OUT_W-1:0] index;
		logic [VALUE_IN_W-1:0]  greater;
		logic                   found;
		logic                   truncated;
		logic                   end_of_run;
	} result_t;

	// Controller states
	typedef enum logic [2:0] {
		ST_LOAD,
		ST_ELEM_RD,
		ST_CMP,
		ST_EMIT_RD,
		ST_EMIT_OUT
	} state_t;

	// Controller to datapath
	typedef struct packed {
		logic load;        // store the accepted item
		logic walk_start;  // last item taken: set up the walk
		logic elem_rd;     // read element at the walk index
		logic pop;         // drop the stack top
		logic push;        // record the answer and push the current value
		logic ans_rd;      // read the answer at the emit index
		logic emit;        // load the result register
	} cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic pop_cond;    // stack not empty and top <= current value
		logic i_zero;      // walk is at element 0
		logic k_last;      // emit index is at the final stored element
		logic out_free;    // result register can take a new result
	} status_t;

endpackage

// ===== design/nge_ctrl.sv =====
`timescale 1ns / 1ps
// Controller of the next greater element block: sequences load, stack walk
// and emit phases. Depends on nge_pkg.
module nge_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            item_valid,
	input  logic            item_last,
	output logic            item_stall,
	output nge_pkg::cmd_t   cmd,
	input  nge_pkg::status_t status
);
	import nge_pkg::*;

	state_t state_q;
	state_t state_nxt;
	logic   item_xfer;

	assign item_xfer = item_valid && (state_q == ST_LOAD);

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
		end else begin
			state_q <= state_nxt;
		end
	end

	// Next state
	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			ST_LOAD: begin
				if (item_xfer && item_last) begin
					state_nxt = ST_ELEM_RD;
				end
			end
			ST_ELEM_RD: begin
				state_nxt = ST_CMP;
			end
			ST_CMP: begin
				if (!status.pop_cond) begin
					state_nxt = status.i_zero ? ST_EMIT_RD : ST_ELEM_RD;
				end
			end
			ST_EMIT_RD: begin
				state_nxt = ST_EMIT_OUT;
			end
			ST_EMIT_OUT: begin
				if (status.out_free) begin
					state_nxt = status.k_last ? ST_LOAD : ST_EMIT_RD;
				end
			end
			default: begin
				state_nxt = ST_LOAD;
			end
		endcase
	end

	// Outputs
	always_comb begin
		cmd        = '0;
		item_stall = 1'b1;
		unique case (state_q)
			ST_LOAD: begin
				item_stall     = 1'b0;
				cmd.load       = item_xfer;
				cmd.walk_start = item_xfer && item_last;
			end
			ST_ELEM_RD: begin
				cmd.elem_rd = 1'b1;
			end
			ST_CMP: begin
				cmd.pop  = status.pop_cond;
				cmd.push = !status.pop_cond;
			end
			ST_EMIT_RD: begin
				cmd.ans_rd = 1'b1;
			end
			ST_EMIT_OUT: begin
				cmd.emit = status.out_free;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

endmodule

// ===== design/nge_dp.sv =====
`timescale 1ns / 1ps
// Datapath of the next greater element block: element, stack and answer
// memories, counters and the result register. Depends on nge_pkg.
module nge_dp #(
	parameter int MAX_ELEMENTS = 64,
	parameter int VALUE_BITS   = 32
) (
	input  logic              clk,
	input  logic              arst_n,
	input  nge_pkg::item_t    item,
	input  nge_pkg::cmd_t     cmd,
	output nge_pkg::status_t  status,
	output logic              result_valid,
	input  logic              result_stall,
	output nge_pkg::result_t  result
);
	import nge_pkg::*;

	localparam int IDX_W = $clog2(MAX_ELEMENTS);
	localparam int CNT_W = $clog2(MAX_ELEMENTS + 1);

	// Memories
	logic [VALUE_BITS-1:0] elem_mem  [MAX_ELEMENTS];
	logic [VALUE_BITS-1:0] stack_mem [MAX_ELEMENTS];
	logic [VALUE_BITS:0]   ans_mem   [MAX_ELEMENTS];

	// Control registers
	logic [CNT_W-1:0] count_q;
	logic             ovf_q;
	logic [CNT_W-1:0] height_q;
	logic [IDX_W-1:0] i_q;
	logic [IDX_W-1:0] k_q;
	logic             out_valid_q;

	// Payload registers
	logic [VALUE_BITS-1:0] cur_q;
	logic [VALUE_BITS-1:0] top_q;
	logic [VALUE_BITS:0]   ans_rd_q;
	result_t               result_q;

	logic                  has_room;
	logic                  found;
	logic [CNT_W-1:0]      below_top;
	logic [VALUE_BITS-1:0] in_value;

	assign has_room  = count_q < CNT_W'(MAX_ELEMENTS);
	assign found     = height_q != '0;
	assign below_top = height_q - CNT_W'(2);
	assign in_value  = VALUE_BITS'(item.value);

	// Status to controller
	assign status.pop_cond = found && (top_q <= cur_q);
	assign status.i_zero   = i_q == '0;
	assign status.k_last   = (CNT_W'(k_q) + CNT_W'(1)) == count_q;
	assign status.out_free = !out_valid_q || !result_stall;

	// Counters and flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			ovf_q       <= 1'b0;
			height_q    <= '0;
			i_q         <= '0;
			k_q         <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.load) begin
				if (has_room) begin
					count_q <= count_q + CNT_W'(1);
				end else begin
					ovf_q <= 1'b1;
				end
			end
			if (cmd.walk_start) begin
				i_q      <= has_room ? count_q[IDX_W-1:0] : IDX_W'(count_q - CNT_W'(1));
				height_q <= '0;
				k_q      <= '0;
			end
			if (cmd.pop) begin
				height_q <= height_q - CNT_W'(1);
			end
			if (cmd.push) begin
				height_q <= height_q + CNT_W'(1);
				i_q      <= i_q - IDX_W'(1);
			end
			if (cmd.emit) begin
				k_q <= k_q + IDX_W'(1);
				if (status.k_last) begin
					count_q <= '0;
					ovf_q   <= 1'b0;
				end
			end
			// Result handshake
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (!result_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Element store
	always_ff @(posedge clk) begin
		if (cmd.load && has_room) begin
			elem_mem[count_q[IDX_W-1:0]] <= in_value;
		end
		if (cmd.elem_rd) begin
			cur_q <= elem_mem[i_q];
		end
	end

	// Stack: top held in top_q, refilled from memory on a pop
	always_ff @(posedge clk) begin
		if (cmd.push) begin
			stack_mem[height_q[IDX_W-1:0]] <= cur_q;
			top_q                          <= cur_q;
		end else if (cmd.pop && (height_q != CNT_W'(1))) begin
			top_q <= stack_mem[below_top[IDX_W-1:0]];
		end
	end

	// Answer store
	always_ff @(posedge clk) begin
		if (cmd.push) begin
			ans_mem[i_q] <= {found, found ? top_q : '0};
		end
		if (cmd.ans_rd) begin
			ans_rd_q <= ans_mem[k_q];
		end
	end

	// Result register
	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			result_q.index      <= INDEX_OUT_W'(k_q);
			result_q.greater    <= VALUE_IN_W'(ans_rd_q[VALUE_BITS-1:0]);
			result_q.found      <= ans_rd_q[VALUE_BITS];
			result_q.truncated  <= ovf_q;
			result_q.end_of_run <= status.k_last;
		end
	end

	assign result_valid = out_valid_q;
	assign result       = result_q;

endmodule

// ===== design/next_greater_element_top.sv =====
`timescale 1ns / 1ps
// Next greater element, top level: controller plus datapath.
// Depends on nge_pkg, nge_ctrl and nge_dp.
//
// Items are taken one per cycle until one marked last arrives; up to
// MAX_ELEMENTS are stored, later ones are dropped and flag truncated. The
// block then stalls input and walks the stored values right to left with a
// monotonic stack held in a single-port memory: each element is read, then
// the stack is popped while its top is not greater, then the element is
// pushed with its answer recorded. Results follow in index order through
// the answer memory read and the result register. Input is taken again as
// soon as the last result sits in the result register.
module next_greater_element_top #(
	parameter int MAX_ELEMENTS = 64,
	parameter int VALUE_BITS   = 32
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             item_valid,
	output logic             item_stall,
	input  nge_pkg::item_t   item,
	output logic             result_valid,
	input  logic             result_stall,
	output nge_pkg::result_t result
);
	import nge_pkg::*;

	cmd_t    cmd;
	status_t status;

	// Sequencer
	nge_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_last  (item.last),
		.item_stall (item_stall),
		.cmd        (cmd),
		.status     (status)
	);

	// Stores, stack and result register
	nge_dp #(
		.MAX_ELEMENTS (MAX_ELEMENTS),
		.VALUE_BITS   (VALUE_BITS)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.item         (item),
		.cmd          (cmd),
		.status       (status),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

endmodule
